### hw/rtl/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg
// shared types and codes of the sorted array set unit
// ----------------------------------------------------------------------------
package sas_pkg;

  // operation codes, the unused code acts as a query
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned OUT_COUNT_W = 7;

  typedef struct packed {
    logic [1:0]         op;
    logic [VALUE_W-1:0] value;
  } in_item_t;

  typedef struct packed {
    logic                   was_present;
    logic                   full_refused;
    logic [OUT_COUNT_W-1:0] element_count;
  } out_item_t;

endpackage

### hw/rtl/sorted_array_set_unit.sv
// ----------------------------------------------------------------------------
// sorted_array_set_unit
// set of distinct values kept in ascending order in a ram of CAPACITY entries
// ----------------------------------------------------------------------------
// usage
//   in channel  : in_valid / in_ready / in_data (op, value), one transfer per
//                 operation: insert, delete or membership query
//   out channel : out_valid / out_ready / out_data, exactly one transfer per
//                 operation: was_present, full_refused, element_count
//   in_ready is high only while the sequencer is idle; one operation is
//   worked on at a time
//   sequence: a setup step, then binary search steps that each probe the
//   midpoint and compare the returned entry, then for an insert of a new
//   value the entries from pos up move up by one, top first, and the key
//   is written at pos; for a delete of a present value the entries above
//   pos move down by one; then the result is loaded into the output register
//   the entry moves go through the single ram write port, one entry per cycle
//   reset clears the element count and the output valid flag; ram contents are
//   not cleared, only entries below the count are ever read
//   a stalled receiver holds the result in the output register; the
//   sequencer waits in its finish state until that register is free
// ----------------------------------------------------------------------------
module sorted_array_set_unit #(
  parameter int unsigned CAPACITY   = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  sas_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output sas_pkg::out_item_t  out_data
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned OW = sas_pkg::OUT_COUNT_W;
  localparam int unsigned VW = sas_pkg::VALUE_W;
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_RD   = 6'b000010,
    ST_CMP  = 6'b000100,
    ST_INS  = 6'b001000,
    ST_DEL  = 6'b010000,
    ST_FIN  = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [1:0]             op_r, op_nxt;
  logic [DATA_WIDTH-1:0]  key_r, key_nxt;
  logic [CW-1:0]          lo_r, lo_nxt;
  logic [CW-1:0]          hi_r, hi_nxt;
  logic                   eq_r, eq_nxt;
  logic                   refused_r, refused_nxt;
  logic [CW-1:0]          idx_r, idx_nxt;
  logic [CW-1:0]          wa_r, wa_nxt;
  logic                   wr_pend_r, wr_pend_nxt;
  logic [CW-1:0]          count_r, count_nxt;
  logic                   out_valid_r, out_valid_nxt;
  sas_pkg::out_item_t     out_data_r, out_data_nxt;

  logic [DATA_WIDTH-1:0]  in_key;
  logic [OW-1:0]          count_out;
  logic [CW-1:0]          idx_dec;

  // ram ports
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [DATA_WIDTH-1:0]  ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [DATA_WIDTH-1:0]  ram_rdata;

  // search step unit outputs
  logic [CW-1:0]          step_mid;
  logic [CW-1:0]          step_lo;
  logic [CW-1:0]          step_hi;
  logic                   step_more;
  logic                   step_hit;

  // only the low DATA_WIDTH bits of the value take part
  if (DATA_WIDTH <= VW) begin : g_key_narrow
    assign in_key = in_data.value[DATA_WIDTH-1:0];
  end else begin : g_key_wide
    assign in_key = {{(DATA_WIDTH-VW){1'b0}}, in_data.value};
  end

  // reported count is the element count masked to the field width
  if (CW >= OW) begin : g_cnt_trunc
    assign count_out = count_r[OW-1:0];
  end else begin : g_cnt_ext
    assign count_out = {{(OW-CW){1'b0}}, count_r};
  end

  assign idx_dec = idx_r - ONE_C;

  sas_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sas_step #(
    .CW (CW),
    .DW (DATA_WIDTH)
  ) u_step (
    .lo     (lo_r),
    .hi     (hi_r),
    .entry  (ram_rdata),
    .key    (key_r),
    .mid    (step_mid),
    .lo_nxt (step_lo),
    .hi_nxt (step_hi),
    .more   (step_more),
    .hit    (step_hit)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    key_nxt       = key_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    eq_nxt        = eq_r;
    refused_nxt   = refused_r;
    idx_nxt       = idx_r;
    wa_nxt        = wa_r;
    wr_pend_nxt   = wr_pend_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = wa_r[AW-1:0];
    ram_wdata     = ram_rdata;
    ram_raddr     = step_mid[AW-1:0];

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.op;
          key_nxt     = in_key;
          lo_nxt      = '0;
          hi_nxt      = count_r;
          eq_nxt      = 1'b0;
          refused_nxt = 1'b0;
          wr_pend_nxt = 1'b0;
          state_nxt   = ST_RD;
        end
      end
      ST_RD: begin
        if (step_more) begin
          // probe the midpoint, data returns next cycle
          ram_raddr = step_mid[AW-1:0];
          state_nxt = ST_CMP;
        end else begin
          // search done: lo is the insert position, eq tells presence
          case (op_r)
            sas_pkg::OP_INSERT: begin
              if (eq_r) begin
                state_nxt = ST_FIN;
              end else if (count_r >= CAP_C) begin
                refused_nxt = 1'b1;
                state_nxt   = ST_FIN;
              end else begin
                idx_nxt   = count_r;
                state_nxt = ST_INS;
              end
            end
            sas_pkg::OP_DELETE: begin
              if (eq_r) begin
                idx_nxt   = lo_r + ONE_C;
                state_nxt = ST_DEL;
              end else begin
                state_nxt = ST_FIN;
              end
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_CMP: begin
        lo_nxt = step_lo;
        hi_nxt = step_hi;
        // the last probe that set hi is the entry at the final position
        if (step_hi != hi_r) begin
          eq_nxt = step_hit;
        end
        state_nxt = ST_RD;
      end
      ST_INS: begin
        // move entries up by one, top first: read idx-1, write idx in the next cycle
        if (wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_r > lo_r) begin
          ram_raddr   = idx_dec[AW-1:0];
          wa_nxt      = idx_r;
          idx_nxt     = idx_dec;
          wr_pend_nxt = 1'b1;
        end else if (!wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = lo_r[AW-1:0];
          ram_wdata = key_r;
          count_nxt = count_r + ONE_C;
          state_nxt = ST_FIN;
        end else begin
          wr_pend_nxt = 1'b0;
        end
      end
      ST_DEL: begin
        // close the gap, bottom first: read idx, write idx-1 in the next cycle
        if (wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = wa_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_r < count_r) begin
          ram_raddr   = idx_r[AW-1:0];
          wa_nxt      = idx_dec;
          idx_nxt     = idx_r + ONE_C;
          wr_pend_nxt = 1'b1;
        end else if (!wr_pend_r) begin
          count_nxt = count_r - ONE_C;
          state_nxt = ST_FIN;
        end else begin
          wr_pend_nxt = 1'b0;
        end
      end
      ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.was_present   = eq_r;
          out_data_nxt.full_refused  = refused_r;
          out_data_nxt.element_count = count_out;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    eq_r       <= eq_nxt;
    refused_r  <= refused_nxt;
    idx_r      <= idx_nxt;
    wa_r       <= wa_nxt;
    out_data_r <= out_data_nxt;
  end

  // element count never passes the store size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("element count above capacity");

  // an accepted operation keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // a pending shift write exists only while entries are being moved
  a_pend_in_shift: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == ST_INS || state_r == ST_DEL))
    else $error("pending write outside a shift");

  // the count moves by at most one per operation
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != $past(count_r)) |->
      (count_r == $past(count_r) + ONE_C || count_r == $past(count_r) - ONE_C))
    else $error("count changed by more than one");

endmodule

### hw/rtl/sas_ram.sv
// ----------------------------------------------------------------------------
// sas_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module sas_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/sas_step.sv
// ----------------------------------------------------------------------------
// sas_step
// shared compare unit: one lower-bound binary search step
// ----------------------------------------------------------------------------
module sas_step #(
  parameter int unsigned CW = 7,
  parameter int unsigned DW = 32
) (
  input  logic [CW-1:0] lo,
  input  logic [CW-1:0] hi,
  input  logic [DW-1:0] entry,
  input  logic [DW-1:0] key,
  output logic [CW-1:0] mid,
  output logic [CW-1:0] lo_nxt,
  output logic [CW-1:0] hi_nxt,
  output logic          more,
  output logic          hit
);

  localparam logic [CW-1:0] ONE_C = CW'(1);

  logic [CW-1:0] span;
  logic          less;

  assign span   = hi - lo;
  assign mid    = lo + (span >> 1);
  assign more   = (lo < hi);
  assign less   = (entry < key);
  assign hit    = (entry == key);
  // entry below key moves the low bound past mid, else mid becomes the bound
  assign lo_nxt = less ? (mid + ONE_C) : lo;
  assign hi_nxt = less ? hi : mid;

endmodule
